FILE: rtl/bdph_pkg.sv
// Package for the button debounce / press-hold unit.
// Holds timer width, register indexes, reset values, payload structs and helpers.
// No dependencies.
package bdph_pkg;

  localparam int TIMER_BITS = 16;               // width of the tick counters (8..32)
  localparam int CFG_W      = 16;               // width of the time registers
  localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL  = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_TIME_RST     = 16'd1000;
  localparam logic             ACTIVE_LEVEL_RST  = 1'b0;

  localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

  typedef struct packed {
    logic pin_level;
    logic ack_press;
  } bdph_in_t;

  typedef struct packed {
    logic is_pressed;
    logic press_event;
    logic held_event;
  } bdph_out_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } bdph_cfg_wr_t;

  // saturating increment of a tick counter
  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + {{(TIMER_BITS-1){1'b0}}, 1'b1};
  endfunction

endpackage

FILE: rtl/bdph_core.sv
// Debounce and press/hold state with its configuration registers.
// One tick is processed per step pulse; the result is combinational.
// Depends on bdph_pkg.
module bdph_core (
  input  logic                  clk,
  input  logic                  rst,
  input  bdph_pkg::bdph_cfg_wr_t cfg_wr,
  input  logic                  step,
  input  bdph_pkg::bdph_in_t    item,
  output bdph_pkg::bdph_out_t   result
);
  import bdph_pkg::*;

  logic [CFG_W-1:0]      debounce_time;
  logic [CFG_W-1:0]      hold_time;
  logic                  active_level;

  logic                  stable_state, stable_state_next;
  logic                  last_raw;
  logic [TIMER_BITS-1:0] since_change, since_change_next;
  logic [TIMER_BITS-1:0] since_press, since_press_next, since_press_base;
  logic                  press_pending, press_pending_next, press_pending_set;
  logic                  hold_reported, hold_reported_next, hold_reported_base;

  logic                  accept, accepted_active, pressed, held;

  always_comb begin
    since_change_next = (item.pin_level != last_raw) ? '0 : sat_inc(since_change);
    accept = (item.pin_level != stable_state) &&
             (CMP_W'(since_change_next) >= CMP_W'(debounce_time));
    stable_state_next = accept ? item.pin_level : stable_state;
    accepted_active   = accept && (item.pin_level == active_level);
    pressed           = (stable_state_next == active_level);

    since_press_base  = accept ? '0 : since_press;
    since_press_next  = (pressed && !accepted_active) ? sat_inc(since_press_base)
                                                      : since_press_base;
    hold_reported_base = accept ? 1'b0 : hold_reported;
    held = pressed && !hold_reported_base &&
           (CMP_W'(since_press_next) >= CMP_W'(hold_time));
    hold_reported_next = hold_reported_base | held;

    press_pending_set  = press_pending | accepted_active;
    press_pending_next = item.ack_press ? 1'b0 : press_pending_set;

    result.is_pressed  = pressed;
    result.press_event = press_pending_set;
    result.held_event  = held;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= DEBOUNCE_TIME_RST;
      hold_time     <= HOLD_TIME_RST;
      active_level  <= ACTIVE_LEVEL_RST;
      stable_state  <= ~ACTIVE_LEVEL_RST;
      last_raw      <= ~ACTIVE_LEVEL_RST;
      since_change  <= '0;
      since_press   <= '0;
      press_pending <= 1'b0;
      hold_reported <= 1'b0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_DEBOUNCE_TIME: debounce_time <= cfg_wr.data;
        REG_HOLD_TIME:     hold_time     <= cfg_wr.data;
        REG_ACTIVE_LEVEL: begin
          // new polarity: back to idle for the new inactive level
          active_level  <= cfg_wr.data[0];
          stable_state  <= ~cfg_wr.data[0];
          last_raw      <= ~cfg_wr.data[0];
          since_change  <= '0;
          since_press   <= '0;
          press_pending <= 1'b0;
          hold_reported <= 1'b0;
        end
        default: ;
      endcase
    end else if (step) begin
      stable_state  <= stable_state_next;
      last_raw      <= item.pin_level;
      since_change  <= since_change_next;
      since_press   <= since_press_next;
      press_pending <= press_pending_next;
      hold_reported <= hold_reported_next;
    end
  end

endmodule

FILE: rtl/button_debounce_press_hold_unit.sv
// Top level of the button debounce / press-hold unit.
// Two-stage valid/stall pipeline around bdph_core.
// Depends on bdph_pkg and bdph_core.

// One transaction on the item channel is one millisecond tick: the raw pin
// level and an acknowledge for the latched press event. Every tick gives
// exactly one result transaction (is_pressed, press_event, held_event).
// The tick is first captured in an input register; when the output register
// can take a result, the debounce/press-hold update runs as a single pass of
// short logic against the state registers and the result lands in the output
// register. A new tick is taken every cycle while the result side keeps up:
// throughput is one transaction per cycle, set by the state update
// loop in the core. The item channel stalls only when both the
// input register and the output register are full and the
// result side is stalling. Registers (debounce_time, hold_time, active_level)
// are written through the cfg channel, which is always ready; writes are to be
// made only while no tick is in flight. Writing active_level returns the
// debounce state to idle for the new inactive level. Counters are
// TIMER_BITS wide and saturate. Reset is synchronous, active high.
module button_debounce_press_hold_unit (
  input  logic                                clk,
  input  logic                                rst,
  // tick channel
  input  logic                                item_valid,
  output logic                                item_stall,
  input  bdph_pkg::bdph_in_t                  item,
  // result channel
  output logic                                result_valid,
  input  logic                                result_stall,
  output bdph_pkg::bdph_out_t                 result,
  // register write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bdph_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bdph_pkg::CFG_W-1:0]          cfg_data
);
  import bdph_pkg::*;

  bdph_in_t     in_reg;       // captured tick (payload, no reset)
  logic         in_reg_valid;
  bdph_out_t    core_result;
  bdph_cfg_wr_t cfg_wr;

  logic out_load;   // output register free or being emptied this cycle
  logic step;       // captured tick goes through the core into the output register
  logic in_load;    // new tick accepted

  assign out_load   = !result_valid || !result_stall;
  assign step       = in_reg_valid && out_load;
  assign item_stall = in_reg_valid && !out_load;
  assign in_load    = item_valid && !item_stall;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  bdph_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .step   (step),
    .item   (in_reg),
    .result (core_result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_load) begin
      in_reg_valid <= 1'b1;
    end else if (step) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_reg <= item;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= core_result;
    end
  end

endmodule
